### rtl/core/interval_merge_window_cut_defines.svh
// Assertion macros used by the checker file.
`ifndef INTERVAL_MERGE_WINDOW_CUT_DEFINES_SVH
`define INTERVAL_MERGE_WINDOW_CUT_DEFINES_SVH

// Check a property on every clock edge, reset included.
`define IMWC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

// Check a property only while reset is released.
`define IMWC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`endif

### rtl/core/imwc_pkg.sv
package imwc_pkg;

    localparam logic [1:0] ACT_DELETE  = 2'd0;
    localparam logic [1:0] ACT_REWRITE = 2'd1;
    localparam logic [1:0] ACT_INSERT  = 2'd2;

    localparam logic [1:0] MODE_EDIT     = 2'd0;
    localparam logic [1:0] MODE_COPY_CUT = 2'd1;

    localparam logic [1:0] CFG_WIN_START = 2'd0;
    localparam logic [1:0] CFG_WIN_END   = 2'd1;
    localparam logic [1:0] CFG_MODE      = 2'd2;
    localparam logic [1:0] CFG_DEL_SRC   = 2'd3;

    typedef struct packed {
        logic signed [63:0] in_low;
        logic signed [63:0] in_high;
        logic signed [63:0] in_time;
        logic        [47:0] in_row;
        logic               end_of_scan;
    } t_in;

    typedef struct packed {
        logic        [1:0]  action;
        logic        [47:0] out_row;
        logic signed [63:0] out_low;
        logic signed [63:0] out_high;
        logic signed [63:0] out_time;
        logic               last_of_run;
    } t_res;

    // Snapshot of a held range that is to be flushed.
    typedef struct packed {
        logic               valid;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] tm;
        logic        [47:0] row;
        logic               expanded;
    } t_flush;

    // Work queued from front to back for one input transaction.
    typedef struct packed {
        logic        [47:0] row;
        logic               mdel;
        t_flush             f1;
        logic               dsrc;
        t_flush             f2;
    } t_cmd;

    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_pair;

    function automatic t_res make_res(logic [1:0] act, logic [47:0] row,
                                      logic signed [63:0] lo, logic signed [63:0] hi,
                                      logic signed [63:0] tm);
        t_res r;
        r.action      = act;
        r.out_row     = row;
        r.out_low     = lo;
        r.out_high    = hi;
        r.out_time    = tm;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic t_res make_del(logic [47:0] row);
        return make_res(ACT_DELETE, row, 64'sd0, 64'sd0, 64'sd0);
    endfunction

    // Cut a flushed range against [ws, we) and give up to two results.
    function automatic t_pair flush_gen(t_flush f, logic [1:0] mode,
                                        logic signed [63:0] ws, logic signed [63:0] we);
        t_pair p;
        logic  lo_lt_ws;
        logic  hi_lt_ws;
        logic  lo_lt_we;
        logic  hi_lt_we;
        logic  has_lo;
        logic  has_up;
        t_res  whole;
        t_res  lower;
        t_res  upper;
        t_res  first;
        lo_lt_ws = $signed(f.lo) < $signed(ws);
        hi_lt_ws = $signed(f.hi) < $signed(ws);
        lo_lt_we = $signed(f.lo) < $signed(we);
        hi_lt_we = $signed(f.hi) < $signed(we);
        has_lo   = lo_lt_ws && !hi_lt_ws;
        has_up   = lo_lt_we && !hi_lt_we;
        whole    = make_res(ACT_INSERT, 48'd0, f.lo, f.hi, f.tm);
        lower    = make_res(ACT_INSERT, 48'd0, f.lo, ws - 64'sd1, f.tm);
        upper    = make_res(ACT_INSERT, 48'd0, we, f.hi, f.tm);
        first    = has_lo ? lower : upper;
        p.v0 = 1'b0;
        p.v1 = 1'b0;
        p.r0 = whole;
        p.r1 = upper;
        if (mode[1]) begin
            p.v0 = 1'b1;
        end else if (!lo_lt_ws && hi_lt_we) begin
            // enclosed: drop the row in place, nothing to copy
            p.v0 = (mode == MODE_EDIT);
            p.r0 = make_del(f.row);
        end else if (has_lo || has_up) begin
            p.v0 = 1'b1;
            p.v1 = has_lo && has_up;
            p.r0 = first;
            if (mode == MODE_EDIT) begin
                p.r0.action  = ACT_REWRITE;
                p.r0.out_row = f.row;
            end
        end else if (mode == MODE_COPY_CUT) begin
            p.v0 = 1'b1;
        end else begin
            p.v0 = f.expanded;
            p.r0.action  = ACT_REWRITE;
            p.r0.out_row = f.row;
        end
        return p;
    endfunction

endpackage

### rtl/core/imwc_front.sv
module imwc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  imwc_pkg::t_in    i_item,
    input  logic [1:0]       i_mode,
    input  logic             i_del_src,
    output imwc_pkg::t_cmd   o_cmd
);
    import imwc_pkg::*;

    logic               r_holding;
    logic signed [63:0] r_low;
    logic signed [63:0] r_high;
    logic signed [63:0] r_time;
    logic        [47:0] r_row;
    logic               r_expanded;

    logic               merge;
    logic               grow;
    t_flush             held;
    t_flush             n_held;

    always_comb begin
        merge = r_holding && !($signed(r_high) < $signed(i_item.in_low));
        grow  = $signed(r_high) < $signed(i_item.in_high);

        held.valid    = r_holding && !merge;
        held.lo       = r_low;
        held.hi       = r_high;
        held.tm       = r_time;
        held.row      = r_row;
        held.expanded = r_expanded;

        // range held once this transaction is taken in
        n_held = held;
        n_held.valid = i_item.end_of_scan;
        if (merge) begin
            if (grow) begin
                n_held.hi       = i_item.in_high;
                n_held.expanded = 1'b1;
            end
        end else begin
            n_held.lo       = i_item.in_low;
            n_held.hi       = i_item.in_high;
            n_held.tm       = i_item.in_time;
            n_held.row      = i_item.in_row;
            n_held.expanded = 1'b0;
        end

        o_cmd.row  = i_item.in_row;
        o_cmd.mdel = merge && (i_mode == MODE_EDIT);
        o_cmd.f1   = held;
        o_cmd.dsrc = i_del_src;
        o_cmd.f2   = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding  <= 1'b0;
            r_expanded <= 1'b0;
        end else if (i_push) begin
            r_holding  <= !i_item.end_of_scan;
            r_expanded <= n_held.expanded && !i_item.end_of_scan;
        end
        if (i_push) begin
            r_low  <= n_held.lo;
            r_high <= n_held.hi;
            r_time <= n_held.tm;
            r_row  <= n_held.row;
        end
    end

endmodule

### rtl/core/imwc_queue.sv
module imwc_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  imwc_pkg::t_cmd   i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output imwc_pkg::t_cmd   o_data
);
    import imwc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/imwc_back.sv
module imwc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  imwc_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    input  logic [1:0]         i_mode,
    input  logic signed [63:0] i_win_start,
    input  logic signed [63:0] i_win_end,
    input  logic               i_stall,
    output logic               o_valid,
    output imwc_pkg::t_res     o_data
);
    import imwc_pkg::*;

    localparam int NS = 5;

    logic [2:0] r_ptr;
    logic       r_out_valid;
    t_res       r_out;

    t_pair      p1;
    t_pair      p2;
    logic       slot_v [NS];
    t_res       slot_r [NS];
    logic [2:0] sel;
    logic       found;
    logic       more;
    logic       load_ok;
    logic       emit;
    t_res       pick;

    always_comb begin
        p1 = flush_gen(i_cmd.f1, i_mode, i_win_start, i_win_end);
        p2 = flush_gen(i_cmd.f2, i_mode, i_win_start, i_win_end);

        slot_v[0] = i_cmd.mdel || (i_cmd.f1.valid && p1.v0);
        slot_r[0] = i_cmd.mdel ? make_del(i_cmd.row) : p1.r0;
        slot_v[1] = i_cmd.f1.valid && p1.v1;
        slot_r[1] = p1.r1;
        slot_v[2] = i_cmd.dsrc;
        slot_r[2] = make_del(i_cmd.row);
        slot_v[3] = i_cmd.f2.valid && p2.v0;
        slot_r[3] = p2.r0;
        slot_v[4] = i_cmd.f2.valid && p2.v1;
        slot_r[4] = p2.r1;

        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NS; i++) begin
            if (!found && slot_v[i] && (3'(i) >= r_ptr)) begin
                found = 1'b1;
                sel   = 3'(i);
            end
        end
        more = 1'b0;
        for (int j = 0; j < NS; j++) begin
            if (slot_v[j] && (3'(j) > sel)) begin
                more = 1'b1;
            end
        end

        pick = slot_r[sel];
        pick.last_of_run = !more;

        load_ok = !r_out_valid || !i_stall;
        emit    = i_valid && found && load_ok;
        // a transaction with no results leaves at once
        o_pop   = i_valid && ((found && load_ok && !more) || !found);
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ptr <= '0;
            end else if (emit) begin
                r_ptr <= sel + 3'd1;
            end
            if (load_ok) begin
                r_out_valid <= emit;
            end
        end
        if (emit) begin
            r_out <= pick;
        end
    end

endmodule

### rtl/core/interval_merge_window_cut.sv
// Sorted interval merge with window cut. Ranges arrive ordered by low bound
// and fold into one running merged range; a range merges only when its low
// bound is not above the held high bound. A range that does not merge, and
// an end_of_scan transaction, flush the held range, which is cut against the
// window [window_start, window_end) and turned into delete, rewrite or insert
// results as source_mode selects. Timing: the front takes one transaction per
// cycle while the command queue (QDEPTH entries) has room; the back emits one
// result per cycle while the output is not stalled. Each transaction causes
// 0 to 5 results and still passes through the back when it causes none.
// Sustained throughput is set by the back's single output register. Results
// leave through an output register and may be stalled without stopping the
// front until the queue fills. No memory is cleared after reset. Write
// configuration only while no transaction is in flight.
module interval_merge_window_cut #(
    parameter int QDEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input transactions
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  imwc_pkg::t_in   i_in_data,
    // result transactions
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output imwc_pkg::t_res  o_out_data,
    // configuration writes
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data
);
    import imwc_pkg::*;

    logic signed [63:0] r_win_start;
    logic signed [63:0] r_win_end;
    logic        [1:0]  r_mode;
    logic               r_del_src;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_cmd  cmd_in;
    t_cmd  cmd_out;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= 64'sd0;
            r_win_end   <= 64'sd0;
            r_mode      <= MODE_EDIT;
            r_del_src   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_START: r_win_start <= $signed(i_cfg_data);
                CFG_WIN_END:   r_win_end   <= $signed(i_cfg_data);
                CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                CFG_DEL_SRC:   r_del_src   <= i_cfg_data[0];
                default:       r_del_src   <= r_del_src;
            endcase
        end
    end

    // Accept whenever the queue has a free slot.
    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    // Front: update the merged range and classify the transaction.
    imwc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_in_data),
        .i_mode    (r_mode),
        .i_del_src (r_del_src),
        .o_cmd     (cmd_in)
    );

    // Decouple front and back.
    imwc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    // Back: cut flushed ranges and emit results one per cycle while the output is not stalled.
    imwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .i_mode      (r_mode),
        .i_win_start (r_win_start),
        .i_win_end   (r_win_end),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data)
    );

endmodule

### rtl/core/imwc_checker.sv
`include "interval_merge_window_cut_defines.svh"

module imwc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input imwc_pkg::t_res  o_out_data
);
    import imwc_pkg::*;

    `IMWC_ASSERT_RUN(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    `IMWC_ASSERT_CLK(a_rst_idle, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")
    `IMWC_ASSERT_RUN(a_del_zero, o_out_valid && (o_out_data.action == ACT_DELETE) |-> (o_out_data.out_low == 64'sd0) && (o_out_data.out_high == 64'sd0) && (o_out_data.out_time == 64'sd0), "delete carries range")
    `IMWC_ASSERT_RUN(a_ins_row, o_out_valid && (o_out_data.action == ACT_INSERT) |-> (o_out_data.out_row == 48'd0), "insert carries row")

endmodule

bind interval_merge_window_cut imwc_checker u_imwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
